FILE: design/elwg_pkg.sv
// Shared types and constants for the embedding lookup engine with gradient stores.
package elwg_pkg;

  localparam int VOCAB_MAX_DEF   = 1024;
  localparam int DIM_MAX_DEF     = 64;
  localparam int VALUE_WIDTH_DEF = 16;

  localparam int ROW_IN_W   = 10;
  localparam int IN_VALUE_W = 16;
  localparam int GRAD_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;
  localparam int VOCAB_W    = 11;
  localparam int DIM_W      = 7;

  localparam logic [VOCAB_W-1:0] VOCAB_RST = 11'd1024;
  localparam logic [DIM_W-1:0]   DIM_RST   = 7'd64;

  typedef enum logic [2:0] {
    KIND_WR_WEIGHT = 3'd0,
    KIND_WR_BIAS   = 3'd1,
    KIND_LOOKUP    = 3'd2,
    KIND_GRAD_ADD  = 3'd3,
    KIND_GRAD_READ = 3'd4
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BIAS_EN    = 3'd0,
    CFG_VOCAB_SIZE = 3'd1,
    CFG_EMBED_DIM  = 3'd2,
    CFG_WGRAD_EN   = 3'd3,
    CFG_BGRAD_EN   = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0]                   kind;
    logic [ROW_IN_W-1:0]          row;
    logic [5:0]                   column;
    logic signed [IN_VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [IN_VALUE_W-1:0] out_value;
    logic signed [GRAD_W-1:0]     weight_grad;
    logic signed [GRAD_W-1:0]     bias_grad;
    logic                         row_error;
    logic                         last;
  } res_t;

  typedef struct packed {
    logic clear;
    logic add_w;
    logic add_b;
  } grad_cmd_t;

endpackage

FILE: design/elwg_table.sv
// Weight table and bias vector memories with write saturation and lookup add.
module elwg_table
  import elwg_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int ADDR_W      = 16,
  parameter int COL_W       = 6,
  parameter int DEPTH       = 65536
) (
  input  logic                         clk_i,
  input  logic                         we_w_i,
  input  logic                         we_b_i,
  input  logic [ADDR_W-1:0]            addr_i,
  input  logic signed [IN_VALUE_W-1:0] wdata_i,
  input  logic                         bias_en_i,
  output logic signed [IN_VALUE_W-1:0] value_o
);

  localparam int WORD_W = (VALUE_WIDTH < IN_VALUE_W) ? VALUE_WIDTH : IN_VALUE_W;
  localparam int SAT_W  = GRAD_W + 2;
  localparam logic signed [SAT_W-1:0] VHI =
    SAT_W'((64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1);
  localparam logic signed [SAT_W-1:0] VLO = ~VHI;

  function automatic logic signed [SAT_W-1:0] sat_vw(input logic signed [SAT_W-1:0] v);
    priority if (v > VHI) return VHI;
    else if (v < VLO) return VLO;
    else return v;
  endfunction

  logic signed [WORD_W-1:0] wmem [DEPTH];
  logic signed [WORD_W-1:0] bmem [2**COL_W];
  logic signed [WORD_W-1:0] w_q, b_q;
  logic signed [SAT_W-1:0]  wsat, bias_ext, lsum, lsat;
  logic signed [WORD_W-1:0] wword;

  assign wsat  = sat_vw(SAT_W'(wdata_i));
  assign wword = wsat[WORD_W-1:0];

  always_ff @(posedge clk_i) begin
    if (we_w_i) wmem[addr_i] <= wword;
    if (we_b_i) bmem[addr_i[COL_W-1:0]] <= wword;
    w_q <= wmem[addr_i];
    b_q <= bmem[addr_i[COL_W-1:0]];
  end

  assign bias_ext = bias_en_i ? SAT_W'(b_q) : SAT_W'(0);
  assign lsum     = SAT_W'(w_q) + bias_ext;
  assign lsat     = sat_vw(lsum);
  assign value_o  = lsat[IN_VALUE_W-1:0];

endmodule

FILE: design/elwg_grad.sv
// Weight-gradient and bias-gradient stores with saturating read-modify-write.
module elwg_grad
  import elwg_pkg::*;
#(
  parameter int ADDR_W = 16,
  parameter int COL_W  = 6,
  parameter int DEPTH  = 65536
) (
  input  logic                         clk_i,
  input  grad_cmd_t                    cmd_i,
  input  logic [ADDR_W-1:0]            addr_i,
  input  logic signed [IN_VALUE_W-1:0] value_i,
  output logic signed [GRAD_W-1:0]     wg_o,
  output logic signed [GRAD_W-1:0]     bg_o
);

  localparam logic signed [GRAD_W-1:0] GMAX = {1'b0, {(GRAD_W-1){1'b1}}};
  localparam logic signed [GRAD_W-1:0] GMIN = {1'b1, {(GRAD_W-1){1'b0}}};

  function automatic logic signed [GRAD_W-1:0] sat_add(
    input logic signed [GRAD_W-1:0]     a,
    input logic signed [IN_VALUE_W-1:0] b
  );
    logic signed [GRAD_W:0] s;
    s = (GRAD_W+1)'(a) + (GRAD_W+1)'(b);
    if (s[GRAD_W] != s[GRAD_W-1]) return s[GRAD_W] ? GMIN : GMAX;
    return s[GRAD_W-1:0];
  endfunction

  logic signed [GRAD_W-1:0] wmem [DEPTH];
  logic signed [GRAD_W-1:0] bmem [2**COL_W];
  logic signed [GRAD_W-1:0] wrd_q, brd_q, wsum, bsum;
  logic [ADDR_W-1:0]            addr_q;
  logic signed [IN_VALUE_W-1:0] val_q;

  assign wsum = sat_add(wrd_q, val_q);
  assign bsum = sat_add(brd_q, val_q);

  always_ff @(posedge clk_i) begin
    addr_q <= addr_i;
    val_q  <= value_i;
    wrd_q  <= wmem[addr_i];
    brd_q  <= bmem[addr_i[COL_W-1:0]];
    if (cmd_i.clear) begin
      wmem[addr_i]            <= '0;
      bmem[addr_i[COL_W-1:0]] <= '0;
    end else begin
      if (cmd_i.add_w) wmem[addr_q] <= wsum;
      if (cmd_i.add_b) bmem[addr_q[COL_W-1:0]] <= bsum;
    end
  end

  assign wg_o = wrd_q;
  assign bg_o = brd_q;

endmodule

FILE: design/embedding_lookup_with_grad.sv
// Top level: embedding table engine with lookup streaming and gradient accumulation.
// Usage:
//  - An item transfers on start while busy is low. Register writes use the cfg
//    channel (index, data); cfg_ready_o is always high, write only while idle.
//  - Weight and bias writes give no result.
//  - A lookup of a valid row streams embed_dim results (0 taken as 1, over DIM_MAX
//    as DIM_MAX), one per cycle, through the table read and result registers;
//    last marks the final one. busy stays high until the final element is read.
//    The single read port of the weight table gives one element per cycle.
//  - A gradient add is a read-modify-write of each enabled gradient store.
//  - A gradient read gives one result via the store read and result registers.
//  - A bad-row lookup or gradient read gives an error result in the cycle after it.
//  - Results show on res_o for one cycle with out_strobe_o; the receiver cannot
//    stall them.
//  - After reset a clearing pass zeroes the gradient stores, one entry a cycle,
//    min(VOCAB_MAX,1024) * 2**max(1,ceil(log2(DIM_MAX))) entries (65536 by default);
//    busy is high meanwhile.
module embedding_lookup_with_grad
  import elwg_pkg::*;
#(
  parameter int VOCAB_MAX   = VOCAB_MAX_DEF,
  parameter int DIM_MAX     = DIM_MAX_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  req_t                  req_i,
  output logic                  out_strobe_o,
  output res_t                  res_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int ROWS   = (VOCAB_MAX < 2**ROW_IN_W) ? VOCAB_MAX : 2**ROW_IN_W;
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int DEPTH  = ROWS * (2**COL_W);
  localparam int CNT_W  = COL_W + 1;
  localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(DEPTH - 1);

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_LOOKUP = 5'b00100,
    ST_GRAD   = 5'b01000,
    ST_READ   = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  logic [ADDR_W-1:0]   clr_q, clr_d, addr;
  logic [CNT_W-1:0]    col_q, col_d, dim_cnt;
  logic [ROW_W-1:0]    row_q, row_d;
  logic                rd_vld_q, rd_vld_d, rd_last_q, rd_last_d;
  logic                gw_q, gw_d, gb_q, gb_d;
  logic                out_q, out_d;
  res_t                res_q, res_d;

  logic                bias_en_q, wg_en_q, bg_en_q;
  logic [VOCAB_W-1:0]  vocab_q;
  logic [DIM_W-1:0]    dim_q, dim_eff;

  logic accept, row_ok, col_in_dim, col_in_max, row_in_max;
  logic tbl_we_w, tbl_we_b;
  grad_cmd_t gcmd;
  logic signed [IN_VALUE_W-1:0] tbl_val;
  logic signed [GRAD_W-1:0]     g_wg, g_bg;

  assign busy        = (state_q != ST_IDLE) || rd_vld_q;
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  assign row_in_max = int'(req_i.row) < VOCAB_MAX;
  assign row_ok     = ({1'b0, req_i.row} < vocab_q) && row_in_max;
  assign col_in_max = int'(req_i.column) < DIM_MAX;
  assign col_in_dim = {1'b0, req_i.column} < dim_eff;
  assign dim_cnt    = CNT_W'(dim_eff);

  always_comb begin
    priority if (dim_q == '0) dim_eff = DIM_W'(1);
    else if (int'(dim_q) > DIM_MAX) dim_eff = DIM_W'(DIM_MAX);
    else dim_eff = dim_q;
  end

  always_comb begin
    priority if (state_q == ST_CLEAR) addr = clr_q;
    else if (state_q == ST_LOOKUP) addr = {row_q, col_q[COL_W-1:0]};
    else if (req_i.kind == KIND_LOOKUP) addr = {req_i.row[ROW_W-1:0], COL_W'(0)};
    else addr = {req_i.row[ROW_W-1:0], req_i.column[COL_W-1:0]};
  end

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    col_d     = col_q;
    row_d     = row_q;
    rd_vld_d  = 1'b0;
    rd_last_d = 1'b0;
    gw_d      = gw_q;
    gb_d      = gb_q;
    out_d     = 1'b0;
    res_d     = res_q;
    tbl_we_w  = 1'b0;
    tbl_we_b  = 1'b0;
    gcmd      = '0;
    unique case (state_q)
      ST_CLEAR: begin
        gcmd.clear = 1'b1;
        clr_d      = clr_q + ADDR_W'(1);
        if (clr_q == CLR_LAST) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (req_i.kind)
            KIND_WR_WEIGHT: tbl_we_w = row_in_max && col_in_max;
            KIND_WR_BIAS:   tbl_we_b = col_in_max;
            KIND_LOOKUP: begin
              if (!row_ok) begin
                out_d = 1'b1;
                res_d = '0;
                res_d.row_error = 1'b1;
                res_d.last      = 1'b1;
              end else begin
                rd_vld_d  = 1'b1;
                rd_last_d = (dim_cnt == CNT_W'(1));
                row_d     = req_i.row[ROW_W-1:0];
                col_d     = CNT_W'(1);
                if (dim_cnt != CNT_W'(1)) state_d = ST_LOOKUP;
              end
            end
            KIND_GRAD_ADD: begin
              if (row_ok && col_in_dim) begin
                gw_d    = wg_en_q;
                gb_d    = bias_en_q && bg_en_q;
                state_d = ST_GRAD;
              end
            end
            KIND_GRAD_READ: begin
              if (!row_ok || !col_in_max) begin
                out_d = 1'b1;
                res_d = '0;
                res_d.row_error = !row_ok;
                res_d.last      = 1'b1;
              end else begin
                state_d = ST_READ;
              end
            end
            default: ;
          endcase
        end
      end
      ST_LOOKUP: begin
        rd_vld_d  = 1'b1;
        rd_last_d = (col_q == dim_cnt - CNT_W'(1));
        col_d     = col_q + CNT_W'(1);
        if (rd_last_d) state_d = ST_IDLE;
      end
      ST_GRAD: begin
        gcmd.add_w = gw_q;
        gcmd.add_b = gb_q;
        state_d    = ST_IDLE;
      end
      ST_READ: begin
        out_d             = 1'b1;
        res_d             = '0;
        res_d.weight_grad = g_wg;
        res_d.bias_grad   = g_bg;
        res_d.last        = 1'b1;
        state_d           = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
    if (rd_vld_q) begin
      out_d           = 1'b1;
      res_d           = '0;
      res_d.out_value = tbl_val;
      res_d.last      = rd_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      rd_vld_q  <= 1'b0;
      out_q     <= 1'b0;
      bias_en_q <= 1'b0;
      vocab_q   <= VOCAB_RST;
      dim_q     <= DIM_RST;
      wg_en_q   <= 1'b1;
      bg_en_q   <= 1'b1;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      rd_vld_q <= rd_vld_d;
      out_q    <= out_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_BIAS_EN:    bias_en_q <= cfg_data_i[0];
          CFG_VOCAB_SIZE: vocab_q   <= cfg_data_i[VOCAB_W-1:0];
          CFG_EMBED_DIM:  dim_q     <= cfg_data_i[DIM_W-1:0];
          CFG_WGRAD_EN:   wg_en_q   <= cfg_data_i[0];
          CFG_BGRAD_EN:   bg_en_q   <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    col_q     <= col_d;
    row_q     <= row_d;
    rd_last_q <= rd_last_d;
    gw_q      <= gw_d;
    gb_q      <= gb_d;
    res_q     <= res_d;
  end

  assign out_strobe_o = out_q;
  assign res_o        = res_q;

  elwg_table #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .ADDR_W     (ADDR_W),
    .COL_W      (COL_W),
    .DEPTH      (DEPTH)
  ) u_table (
    .clk_i    (clk_i),
    .we_w_i   (tbl_we_w),
    .we_b_i   (tbl_we_b),
    .addr_i   (addr),
    .wdata_i  (req_i.value),
    .bias_en_i(bias_en_q),
    .value_o  (tbl_val)
  );

  elwg_grad #(
    .ADDR_W(ADDR_W),
    .COL_W (COL_W),
    .DEPTH (DEPTH)
  ) u_grad (
    .clk_i  (clk_i),
    .cmd_i  (gcmd),
    .addr_i (addr),
    .value_i(req_i.value),
    .wg_o   (g_wg),
    .bg_o   (g_bg)
  );

`ifndef SYNTH
  a_lookup_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |=> out_strobe_o)
    else $error("lookup read not delivered");
  a_last_ends_stream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q && rd_last_q |=> !rd_vld_q)
    else $error("lookup stream continues past last");
  a_stream_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o && !res_o.last |=> out_strobe_o)
    else $error("gap inside lookup stream");
  a_rmw_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_GRAD |=> state_q == ST_IDLE)
    else $error("gradient write-back not single cycle");
  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |=> out_strobe_o && res_o.last && !res_o.row_error)
    else $error("gradient read result missing");
`endif

endmodule
